### rtl/kdgp_pkg.sv
// kdgp_pkg: shared types and constants of the k-mer diagonal gap prefilter
// no dependencies; imported by every module of the block
`default_nettype none

package kdgp_pkg;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;
    localparam logic [1:0] CMD_DB    = 2'd3;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;

    localparam int KMER_W = 8;
    localparam int POS_W  = 10;
    localparam int THR_W  = 8;

    typedef struct packed {
        logic              last;
        logic [POS_W-1:0]  qlen;
        logic [POS_W-1:0]  pos;
        logic [KMER_W-1:0] kmer;
        logic [1:0]        cmd;
    } t_op;

endpackage

`default_nettype wire

### rtl/kdgp_front.sv
// kdgp_front: input stage that takes stream items and turns them into ops
// depends on kdgp_pkg; feeds kdgp_queue
`default_nettype none

module kdgp_front (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_en,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire  [kdgp_pkg::IN_TDATA_W-1:0]    i_tdata,
    input  wire  [kdgp_pkg::IN_TUSER_W-1:0]    i_tuser,
    input  wire                                i_tlast,
    output logic                               o_op_valid,
    input  wire                                i_op_ready,
    output kdgp_pkg::t_op                      o_op
);
    import kdgp_pkg::*;

    logic r_valid;
    t_op  r_op;
    t_op  n_op;
    logic accept;

    always_comb begin
        n_op.cmd  = i_tuser[1:0];
        n_op.kmer = i_tdata[KMER_W-1:0];
        n_op.pos  = i_tdata[KMER_W+POS_W-1:KMER_W];
        n_op.qlen = i_tdata[KMER_W+2*POS_W-1:KMER_W+POS_W];
        // the length only matters to a start command
        if (i_tuser[1:0] != CMD_START) begin
            n_op.qlen = '0;
        end
        // last only matters to a database k-mer
        n_op.last = (i_tuser[1:0] == CMD_DB) ? i_tlast : 1'b0;
    end

    assign o_ready    = i_en && (!r_valid || i_op_ready);
    assign accept     = i_valid && o_ready;
    assign o_op_valid = r_valid;
    assign o_op       = r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_op_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= n_op;
        end
    end

endmodule

`default_nettype wire

### rtl/kdgp_queue.sv
// kdgp_queue: two-entry op queue between the front stage and the engine
// depends on kdgp_pkg
`default_nettype none

module kdgp_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push_valid,
    output logic           o_push_ready,
    input  kdgp_pkg::t_op  i_push_data,
    output logic           o_pop_valid,
    input  wire            i_pop_ready,
    output kdgp_pkg::t_op  o_pop_data
);
    import kdgp_pkg::*;

    t_op        r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/kdgp_back.sv
// kdgp_back: engine with the k-mer table, the diagonal counters and the verdict
// depends on kdgp_pkg; takes ops from kdgp_queue, holds the result register
`default_nettype none

module kdgp_back #(
    parameter int KMER_LENGTH    = 4,
    parameter int DIAGONAL_SLOTS = 1024
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [kdgp_pkg::THR_W-1:0]          i_cfg_wdata,
    input  wire                                 i_op_valid,
    output logic                                o_op_ready,
    input  kdgp_pkg::t_op                       i_op,
    output logic                                o_init_done,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [kdgp_pkg::OUT_TDATA_W-1:0]    o_out_data
);
    import kdgp_pkg::*;

    localparam int TW     = 2 * KMER_LENGTH;
    localparam int TDEPTH = 1 << TW;
    localparam int DW     = $clog2(DIAGONAL_SLOTS);
    localparam int MAXD   = (TDEPTH > DIAGONAL_SLOTS) ? TDEPTH : DIAGONAL_SLOTS;
    localparam int CW     = $clog2(MAXD);

    localparam logic [CW:0]   TD_END  = (CW+1)'(TDEPTH);
    localparam logic [CW:0]   DS_END  = (CW+1)'(DIAGONAL_SLOTS);
    localparam logic [CW-1:0] TD_LAST = CW'(TDEPTH - 1);
    localparam logic [CW-1:0] DS_LAST = CW'(DIAGONAL_SLOTS - 1);
    localparam logic [CW-1:0] MX_LAST = CW'(MAXD - 1);
    localparam logic [12:0]   DS_LIM  = 13'(DIAGONAL_SLOTS);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CLR_T = 4'd2;
    localparam logic [3:0] S_CLR_D = 4'd3;
    localparam logic [3:0] S_Q_RD  = 4'd4;
    localparam logic [3:0] S_D_T   = 4'd5;
    localparam logic [3:0] S_D_C   = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    localparam int ENTRY_W = 2 + POS_W;

    logic [3:0]          r_state;
    logic [3:0]          n_state;
    logic [CW-1:0]       r_idx;
    t_op                 r_cur;
    logic [THR_W-1:0]    r_thresh;
    logic [POS_W-1:0]    r_qlen;
    logic                r_conf_valid;
    logic [DW-1:0]       r_conf_diag;
    logic                r_decided;
    logic [DW-1:0]       r_didx;
    logic                r_out_valid;
    logic                r_out_vr;
    logic                r_out_gap;

    logic [ENTRY_W-1:0]  r_tbl [TDEPTH];
    logic [ENTRY_W-1:0]  r_tbl_rd;
    logic [7:0]          r_cnt_mem [DIAGONAL_SLOTS];
    logic [7:0]          r_cnt_rd;

    logic [TW+KMER_W-1:0] key_in_ext;
    logic [TW+KMER_W-1:0] key_cur_ext;
    logic [TW-1:0]        key_in;
    logic [TW-1:0]        key_cur;
    logic                 pop;
    logic                 tbl_we;
    logic [TW-1:0]        tbl_waddr;
    logic [ENTRY_W-1:0]   tbl_wdata;
    logic                 cnt_we;
    logic [DW-1:0]        cnt_waddr;
    logic [7:0]           cnt_wdata;
    logic [DW-1:0]        cnt_raddr;
    logic signed [11:0]   diag;
    logic [12:0]          diag_u;
    logic                 hit_ok;
    logic [7:0]           cnt_new;
    logic                 out_load;
    logic                 is_db;

    assign key_in_ext  = {{TW{1'b0}}, i_op.kmer};
    assign key_cur_ext = {{TW{1'b0}}, r_cur.kmer};
    assign key_in      = key_in_ext[TW-1:0];
    assign key_cur     = key_cur_ext[TW-1:0];

    assign o_op_ready  = (r_state == S_IDLE);
    assign pop         = i_op_valid && o_op_ready;
    assign o_init_done = (r_state != S_INIT);

    // diagonal = db_pos - query_pos + query_len, kept signed
    assign diag    = $signed({2'b00, r_cur.pos}) - $signed({2'b00, r_tbl_rd[POS_W-1:0]})
                   + $signed({2'b00, r_qlen});
    assign diag_u  = {2'b00, diag[10:0]};
    assign hit_ok  = r_tbl_rd[ENTRY_W-1] && !r_tbl_rd[ENTRY_W-2]
                   && !diag[11] && (diag_u < DS_LIM);
    assign cnt_raddr = diag_u[DW-1:0];
    assign cnt_new   = r_cnt_rd + 8'd1;

    assign is_db    = (r_cur.cmd == CMD_DB);
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = r_idx[TW-1:0];
        tbl_wdata = '0;
        cnt_we    = 1'b0;
        cnt_waddr = r_idx[DW-1:0];
        cnt_wdata = '0;
        case (r_state)
            S_INIT: begin
                tbl_we = ({1'b0, r_idx} < TD_END);
                cnt_we = ({1'b0, r_idx} < DS_END);
            end
            S_CLR_T: begin
                tbl_we = 1'b1;
            end
            S_CLR_D: begin
                cnt_we = 1'b1;
            end
            S_Q_RD: begin
                tbl_we    = 1'b1;
                tbl_waddr = key_cur;
                // first sighting keeps the position, any later one marks a repeat
                if (!r_tbl_rd[ENTRY_W-1]) begin
                    tbl_wdata = {2'b10, r_cur.pos};
                end else begin
                    tbl_wdata = {2'b11, {POS_W{1'b0}}};
                end
            end
            S_D_C: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_didx;
                cnt_wdata = cnt_new;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_idx == MX_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (pop) begin
                    case (i_op.cmd)
                        CMD_CLEAR: n_state = S_CLR_T;
                        CMD_QUERY: n_state = S_Q_RD;
                        CMD_START: n_state = S_CLR_D;
                        default:   n_state = r_decided ? S_OUT : S_D_T;
                    endcase
                end
            end
            S_CLR_T: begin
                if (r_idx == TD_LAST) begin
                    n_state = S_OUT;
                end
            end
            S_CLR_D: begin
                if (r_idx == DS_LAST) begin
                    n_state = S_OUT;
                end
            end
            S_Q_RD: begin
                n_state = S_OUT;
            end
            S_D_T: begin
                n_state = hit_ok ? S_D_C : S_OUT;
            end
            S_D_C: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_idx        <= '0;
            r_thresh     <= THR_W'(2);
            r_qlen       <= '0;
            r_conf_valid <= 1'b0;
            r_conf_diag  <= '0;
            r_decided    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            case (r_state)
                S_INIT, S_CLR_T, S_CLR_D: begin
                    r_idx <= r_idx + CW'(1);
                end
                S_IDLE: begin
                    if (pop) begin
                        r_idx <= '0;
                        if (i_op.cmd == CMD_START) begin
                            r_qlen       <= i_op.qlen;
                            r_conf_valid <= 1'b0;
                            r_conf_diag  <= '0;
                            r_decided    <= 1'b0;
                        end
                    end
                end
                S_D_C: begin
                    if (cnt_new == r_thresh) begin
                        if (!r_conf_valid) begin
                            r_conf_valid <= 1'b1;
                            r_conf_diag  <= r_didx;
                        end else if (r_conf_diag != r_didx) begin
                            r_decided <= 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur <= i_op;
        end
        if (r_state == S_D_T) begin
            r_didx <= diag_u[DW-1:0];
        end
        if (out_load) begin
            r_out_vr  <= is_db && (r_decided || r_cur.last);
            r_out_gap <= is_db && r_decided;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl[tbl_waddr] <= tbl_wdata;
        end
        r_tbl_rd <= r_tbl[key_in];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_rd <= r_cnt_mem[cnt_raddr];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {{(OUT_TDATA_W-2){1'b0}}, r_out_gap, r_out_vr};

    a_decided_needs_conf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_decided |-> r_conf_valid)
        else $error("verdict set without a confirmed diagonal");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op_valid && o_op_ready) |-> (r_state == S_IDLE))
        else $error("op taken while engine busy");

    a_gap_implies_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_gap) |-> r_out_vr)
        else $error("gap verdict without verdict ready");

    a_count_after_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_D_C) |-> ($past(r_state) == S_D_T))
        else $error("counter update without table lookup");

endmodule

`default_nettype wire

### rtl/kmer_diagonal_gap_prefilter_core.sv
// kmer_diagonal_gap_prefilter_core: database k-mer hits vote per diagonal
// engine steps per item, set by the engine fsm: counted database k-mer lookup, count, result;
// uncounted lookup, result; after the verdict result only; query k-mer table update, result;
// clear walks every table entry, start every diagonal slot; items pass a front register and queue
// and the engine takes the next item only when idle; after reset a clearing pass over table
// and counters runs before the first item is accepted; threshold resets to 2
`default_nettype none

module kmer_diagonal_gap_prefilter_core #(
    parameter int KMER_LENGTH    = 4,
    parameter int DIAGONAL_SLOTS = 1024
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [kdgp_pkg::THR_W-1:0]         i_cfg_wdata,  // hit_threshold
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [kdgp_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // kmer_value, position, query_len
    input  wire  [kdgp_pkg::IN_TUSER_W-1:0]    s_axis_tuser,  // cmd
    input  wire                                s_axis_tlast,  // last_kmer
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [kdgp_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // verdict_ready, gap_likely
);
    import kdgp_pkg::*;

    logic init_done;
    logic f_valid;
    logic f_ready;
    t_op  f_op;
    logic q_valid;
    logic q_ready;
    t_op  q_op;

    kdgp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (init_done),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_tdata    (s_axis_tdata),
        .i_tuser    (s_axis_tuser),
        .i_tlast    (s_axis_tlast),
        .o_op_valid (f_valid),
        .i_op_ready (f_ready),
        .o_op       (f_op)
    );

    kdgp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  (f_op),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_op)
    );

    kdgp_back #(
        .KMER_LENGTH    (KMER_LENGTH),
        .DIAGONAL_SLOTS (DIAGONAL_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op_valid  (q_valid),
        .o_op_ready  (q_ready),
        .i_op        (q_op),
        .o_init_done (init_done),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

### dv/kmer_diagonal_gap_prefilter_core_tb.sv
// self-checking testbench for kmer_diagonal_gap_prefilter_core: directed and random
// k-mer windows are scored against an in-bench diagonal vote model
// depends on kdgp_pkg and the core rtl
`timescale 1ns / 1ps

module kmer_diagonal_gap_prefilter_core_tb;
    import kdgp_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int SLOTS       = 1024;
    localparam int STALL_LIMIT = 8000;

    typedef struct {
        logic ready;
        logic gap;
    } t_verdict;

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [THR_W-1:0]       i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // kmer_value, position, query_len
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;  // cmd
    logic                   s_axis_tlast = 1'b0;  // last_kmer
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;  // verdict_ready, gap_likely

    kmer_diagonal_gap_prefilter_core #(
        .KMER_LENGTH(4),
        .DIAGONAL_SLOTS(SLOTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    t_op      pending_items[$];
    t_verdict verdict_q[$];
    int       items_queued = 0;
    int       mismatches = 0;

    // vote model state
    logic [11:0]      kmer_tab [TABLE_DEPTH];
    logic [7:0]       diag_cnt [SLOTS];
    logic [9:0]       anchor_diag;
    logic             anchor_valid;
    logic             gap_found;
    logic [9:0]       win_qlen;
    logic [THR_W-1:0] thr_model;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 100)
            $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
    endtask

    function automatic int draw_gap(input logic burst);
        return burst ? 0 : $urandom_range(0, 12);
    endfunction

    task automatic add_item(input logic [1:0] c, input logic [7:0] k, input logic [9:0] p,
                            input logic [9:0] q, input logic l);
        t_op op;
        op.cmd  = c;
        op.kmer = k;
        op.pos  = p;
        op.qlen = q;
        op.last = l;
        pending_items.push_back(op);
        items_queued++;
    endtask

    task automatic score_item(input t_op op);
        int          diag;
        logic [11:0] ent;
        t_verdict    v;
        v.ready = 1'b0;
        v.gap   = 1'b0;
        case (op.cmd)
            CMD_CLEAR: begin
                for (int i = 0; i < TABLE_DEPTH; i++) kmer_tab[i] = '0;
            end
            CMD_QUERY: begin
                if (!kmer_tab[op.kmer][11])
                    kmer_tab[op.kmer] = {2'b10, op.pos};
                else
                    kmer_tab[op.kmer] = {2'b11, 10'd0};
            end
            CMD_START: begin
                win_qlen = op.qlen;
                for (int i = 0; i < SLOTS; i++) diag_cnt[i] = '0;
                anchor_diag  = '0;
                anchor_valid = 1'b0;
                gap_found    = 1'b0;
            end
            default: begin
                ent = kmer_tab[op.kmer];
                if (!gap_found && ent[11] && !ent[10]) begin
                    diag = int'(op.pos) - int'(ent[9:0]) + int'(win_qlen);
                    if (diag >= 0 && diag < SLOTS) begin
                        diag_cnt[diag] = diag_cnt[diag] + 8'd1;
                        if (diag_cnt[diag] == thr_model) begin
                            if (!anchor_valid) begin
                                anchor_valid = 1'b1;
                                anchor_diag  = 10'(diag);
                            end else if (anchor_diag != 10'(diag)) begin
                                gap_found = 1'b1;
                            end
                        end
                    end
                end
                v.ready = gap_found | op.last;
                v.gap   = gap_found;
            end
        endcase
        verdict_q.push_back(v);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || s_axis_tvalid || verdict_q.size() != 0);
    endtask

    task automatic set_threshold(input logic [THR_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        thr_model = v;
    endtask

    // optional clear, query load, optional start, database hits clustered on three diagonals, random tail
    task automatic gen_window();
        logic [7:0] keys[$];
        logic [9:0] qpos[$];
        int         tgt[3];
        int         nq;
        int         ndb;
        int         k;
        int         j;
        int         r;
        logic [7:0] key;
        logic [9:0] p;
        logic [9:0] qlen_w;
        if ($urandom_range(0, 9) != 0)
            add_item(CMD_CLEAR, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                     10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
        nq = $urandom_range(3, 16);
        for (int i = 0; i < nq; i++) begin
            if (keys.size() > 0 && $urandom_range(0, 5) == 0)
                key = keys[$urandom_range(0, keys.size() - 1)];
            else
                key = 8'($urandom_range(0, 255));
            p = 10'($urandom_range(0, 1023));
            add_item(CMD_QUERY, key, p, 10'($urandom_range(0, 1023)),
                     1'($urandom_range(0, 1)));
            keys.push_back(key);
            qpos.push_back(p);
        end
        qlen_w = 10'($urandom_range(0, 1023));
        if ($urandom_range(0, 9) != 0)
            add_item(CMD_START, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                     qlen_w, 1'($urandom_range(0, 1)));
        for (int i = 0; i < 3; i++) begin
            r = $urandom_range(0, 9);
            if (r == 0)
                tgt[i] = -int'($urandom_range(1, 60));
            else if (r == 1)
                tgt[i] = $urandom_range(1024, 1100);
            else
                tgt[i] = $urandom_range(0, 1023);
        end
        ndb = $urandom_range(4, 24);
        for (int i = 0; i < ndb; i++) begin
            if ($urandom_range(0, 3) != 0) begin
                k   = $urandom_range(0, keys.size() - 1);
                j   = $urandom_range(0, 2);
                key = keys[k];
                p   = 10'(int'(qpos[k]) + tgt[j] - int'(qlen_w));
            end else begin
                key = 8'($urandom_range(0, 255));
                p   = 10'($urandom_range(0, 1023));
            end
            add_item(CMD_DB, key, p, 10'($urandom_range(0, 1023)),
                     (i == ndb - 1) || ($urandom_range(0, 15) == 0));
        end
        if ($urandom_range(0, 3) == 0) begin
            r = $urandom_range(1, 4);
            for (int i = 0; i < r; i++)
                add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                         1'($urandom_range(0, 1)));
        end
    endtask

    // driver
    logic drv_burst = 1'b0;
    int   drv_gap = 0;
    t_op  drv_item;

    always @(posedge i_clk) begin
        t_op nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            drv_gap       <= 0;
        end else if (!(s_axis_tvalid && !s_axis_tready)) begin
            if (s_axis_tvalid)
                score_item(drv_item);
            if (drv_gap != 0) begin
                drv_gap       <= drv_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                nxt = pending_items.pop_front();
                drv_item = nxt;
                s_axis_tdata  <= {4'd0, nxt.qlen, nxt.pos, nxt.kmer};
                s_axis_tuser  <= nxt.cmd;
                s_axis_tlast  <= nxt.last;
                s_axis_tvalid <= 1'b1;
                if ($urandom_range(0, 49) == 0)
                    drv_burst = !drv_burst;
                drv_gap <= draw_gap(drv_burst);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    logic rcv_burst = 1'b0;
    int   rcv_stall = 0;

    always @(posedge i_clk) begin
        t_verdict want;
        int       d;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rcv_stall     <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                report_mismatch("result with nothing pending, tdata", int'(m_axis_tdata), 0);
            end else begin
                want = verdict_q.pop_front();
                if (m_axis_tdata[0] !== want.ready)
                    report_mismatch("verdict_ready", int'(m_axis_tdata[0]), int'(want.ready));
                if (m_axis_tdata[1] !== want.gap)
                    report_mismatch("gap_likely", int'(m_axis_tdata[1]), int'(want.gap));
            end
            if ($urandom_range(0, 49) == 0)
                rcv_burst = !rcv_burst;
            d = draw_gap(rcv_burst);
            rcv_stall     <= d;
            m_axis_tready <= (d == 0);
        end else if (rcv_stall != 0) begin
            rcv_stall     <= rcv_stall - 1;
            m_axis_tready <= (rcv_stall == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("** kmer_diagonal_gap_prefilter_core: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) kmer_tab[i] = '0;
        for (int i = 0; i < SLOTS; i++) diag_cnt[i] = '0;
        anchor_diag  = '0;
        anchor_valid = 1'b0;
        gap_found    = 1'b0;
        win_qlen     = '0;
        thr_model    = 8'd2;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // database item before any start, then repeat handling and range edges
        add_item(CMD_DB, 8'h3c, 10'd7, 10'd0, 1'b0);
        add_item(CMD_CLEAR, 8'hff, 10'd1023, 10'd1023, 1'b1);
        add_item(CMD_QUERY, 8'h00, 10'd0, 10'd1023, 1'b0);
        add_item(CMD_QUERY, 8'hff, 10'd1023, 10'd0, 1'b1);
        add_item(CMD_QUERY, 8'h5a, 10'd512, 10'd0, 1'b0);
        add_item(CMD_QUERY, 8'h5a, 10'd3, 10'd0, 1'b0);
        add_item(CMD_QUERY, 8'h5a, 10'd9, 10'd0, 1'b0);
        add_item(CMD_START, 8'hff, 10'd1023, 10'd0, 1'b1);
        add_item(CMD_DB, 8'hff, 10'd0, 10'd0, 1'b0);
        add_item(CMD_DB, 8'h5a, 10'd600, 10'd0, 1'b0);
        add_item(CMD_START, 8'h00, 10'd0, 10'd1023, 1'b0);
        add_item(CMD_DB, 8'h00, 10'd1023, 10'd0, 1'b0);
        add_item(CMD_DB, 8'hff, 10'd1023, 10'd1023, 1'b0);
        add_item(CMD_DB, 8'hff, 10'd1023, 10'd0, 1'b0);
        add_item(CMD_DB, 8'h00, 10'd0, 10'd0, 1'b0);
        add_item(CMD_DB, 8'h00, 10'd1, 10'd0, 1'b0);
        add_item(CMD_DB, 8'hff, 10'd5, 10'd0, 1'b0);
        add_item(CMD_DB, 8'hff, 10'd5, 10'd0, 1'b0);
        add_item(CMD_DB, 8'hff, 10'd6, 10'd0, 1'b1);
        add_item(CMD_CLEAR, 8'h00, 10'd0, 10'd0, 1'b0);
        add_item(CMD_DB, 8'hff, 10'd5, 10'd0, 1'b0);
        add_item(CMD_START, 8'h00, 10'd0, 10'd1023, 1'b0);
        add_item(CMD_DB, 8'h00, 10'd0, 10'd0, 1'b1);
        wait_drained();

        set_threshold(8'd1);
        while (items_queued < 700) gen_window();
        wait_drained();

        // counter wrap past the top threshold, then a second diagonal
        set_threshold(8'd255);
        add_item(CMD_CLEAR, 8'h00, 10'd0, 10'd0, 1'b0);
        add_item(CMD_QUERY, 8'h11, 10'd5, 10'd0, 1'b0);
        add_item(CMD_QUERY, 8'h22, 10'd100, 10'd0, 1'b0);
        add_item(CMD_START, 8'h00, 10'd0, 10'd10, 1'b0);
        for (int i = 0; i < 260; i++) add_item(CMD_DB, 8'h11, 10'd5, 10'd0, 1'b0);
        for (int i = 0; i < 256; i++) add_item(CMD_DB, 8'h22, 10'd200, 10'd0, i == 255);
        wait_drained();

        set_threshold(8'($urandom_range(2, 6)));
        while (items_queued < 1150) gen_window();
        wait_drained();

        set_threshold(8'($urandom_range(3, 8)));
        while (items_queued < 1450) gen_window();
        wait_drained();

        repeat (40) @(posedge i_clk);
        if (verdict_q.size() != 0)
            report_mismatch("results never delivered", 0, verdict_q.size());
        if (mismatches == 0)
            $display("** kmer_diagonal_gap_prefilter_core: PASSED **");
        else
            $display("** kmer_diagonal_gap_prefilter_core: FAILED **");
        $finish;
    end

endmodule
